FILE: rtl/rpoh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpoh_pkg: shared types and constants of the regular polygon engine
// angle steps, cordic constants, sequencer states and the trig unit link
// ----------------------------------------------------------------------------
package rpoh_pkg;

    localparam int MAX_SIDES  = 16;
    localparam int MIN_SIDES  = 3;
    localparam int SIDE_W     = $clog2(MAX_SIDES + 1);
    localparam int COORD_W    = 16;
    localparam int RAD_W      = 15;
    localparam int ANG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // trig values are q1.15 with a little headroom
    localparam int TRIG_W = 18;
    // multiplier second operand: offset from center or radius
    localparam int OPND_W = COORD_W + 1;
    localparam int PROD_W = TRIG_W + OPND_W;

    // cordic datapath
    localparam int CX_W         = 32;
    localparam int CZ_W         = 19;
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam logic signed [CX_W-1:0] CORDIC_X0 = 32'sd652032875;
    // 14-bit in-quadrant angle to q16 radians
    localparam logic [18:0] Z_SCALE = 19'd411775;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_INNER,
        CFG_OUTER,
        CFG_MARGIN,
        CFG_ROTATION,
        CFG_SIDES
    } cfg_index_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROT,
        CS_ROUND
    } cordic_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_LAUNCH,
        ST_TRIG,
        ST_MUL_C,
        ST_MUL_S,
        ST_EVAL,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [ANG_W-1:0] angle;
    } trig_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_rsp_t;

    // quotient and remainder of a fixed numerator over the side count
    typedef struct packed {
        logic [ANG_W-1:0]  quo;
        logic [SIDE_W-1:0] rem;
    } frac_step_t;

    function automatic logic [16:0] atan_q16(input logic [ITER_W-1:0] i);
        logic [16:0] v;
        case (i)
            4'd0:    v = 17'd51472;
            4'd1:    v = 17'd30386;
            4'd2:    v = 17'd16055;
            4'd3:    v = 17'd8150;
            4'd4:    v = 17'd4091;
            4'd5:    v = 17'd2047;
            4'd6:    v = 17'd1024;
            4'd7:    v = 17'd512;
            4'd8:    v = 17'd256;
            4'd9:    v = 17'd128;
            4'd10:   v = 17'd64;
            4'd11:   v = 17'd32;
            4'd12:   v = 17'd16;
            4'd13:   v = 17'd8;
            4'd14:   v = 17'd4;
            default: v = 17'd2;
        endcase
        return v;
    endfunction

    // one full turn over k
    function automatic frac_step_t full_step(input logic [SIDE_W-1:0] k);
        frac_step_t v;
        case (k)
            5'd3:    v = '{quo: 16'd21845, rem: 5'd1};
            5'd4:    v = '{quo: 16'd16384, rem: 5'd0};
            5'd5:    v = '{quo: 16'd13107, rem: 5'd1};
            5'd6:    v = '{quo: 16'd10922, rem: 5'd4};
            5'd7:    v = '{quo: 16'd9362,  rem: 5'd2};
            5'd8:    v = '{quo: 16'd8192,  rem: 5'd0};
            5'd9:    v = '{quo: 16'd7281,  rem: 5'd7};
            5'd10:   v = '{quo: 16'd6553,  rem: 5'd6};
            5'd11:   v = '{quo: 16'd5957,  rem: 5'd9};
            5'd12:   v = '{quo: 16'd5461,  rem: 5'd4};
            5'd13:   v = '{quo: 16'd5041,  rem: 5'd3};
            5'd14:   v = '{quo: 16'd4681,  rem: 5'd2};
            5'd15:   v = '{quo: 16'd4369,  rem: 5'd1};
            5'd16:   v = '{quo: 16'd4096,  rem: 5'd0};
            default: v = '{quo: 16'd0,     rem: 5'd0};
        endcase
        return v;
    endfunction

    // half a turn over k, first edge normal
    function automatic frac_step_t half_step(input logic [SIDE_W-1:0] k);
        frac_step_t v;
        case (k)
            5'd3:    v = '{quo: 16'd10922, rem: 5'd2};
            5'd4:    v = '{quo: 16'd8192,  rem: 5'd0};
            5'd5:    v = '{quo: 16'd6553,  rem: 5'd3};
            5'd6:    v = '{quo: 16'd5461,  rem: 5'd2};
            5'd7:    v = '{quo: 16'd4681,  rem: 5'd1};
            5'd8:    v = '{quo: 16'd4096,  rem: 5'd0};
            5'd9:    v = '{quo: 16'd3640,  rem: 5'd8};
            5'd10:   v = '{quo: 16'd3276,  rem: 5'd8};
            5'd11:   v = '{quo: 16'd2978,  rem: 5'd10};
            5'd12:   v = '{quo: 16'd2730,  rem: 5'd8};
            5'd13:   v = '{quo: 16'd2520,  rem: 5'd8};
            5'd14:   v = '{quo: 16'd2340,  rem: 5'd8};
            5'd15:   v = '{quo: 16'd2184,  rem: 5'd8};
            5'd16:   v = '{quo: 16'd2048,  rem: 5'd0};
            default: v = '{quo: 16'd0,     rem: 5'd0};
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/rpoh_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpoh_cordic: iterative sine and cosine of a turn fraction
// one rotation step per cycle, quadrant folded in at the end
// ----------------------------------------------------------------------------
module rpoh_cordic (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rpoh_pkg::trig_req_t  req,
    output rpoh_pkg::trig_rsp_t       rsp
);

    rpoh_pkg::cordic_state_t state_reg, state_next;

    logic [rpoh_pkg::ITER_W-1:0]      iter_reg;
    logic signed [rpoh_pkg::CX_W-1:0] x_reg, y_reg;
    logic signed [rpoh_pkg::CZ_W-1:0] z_reg;
    logic [1:0]                       quad_reg;

    logic [32:0]                        z_prod;
    logic [32:0]                        z_rnd;
    logic signed [rpoh_pkg::CZ_W-1:0]   z_init;
    logic signed [rpoh_pkg::CX_W-1:0]   x_sh, y_sh;
    logic signed [rpoh_pkg::CZ_W-1:0]   atan_ext;
    logic signed [rpoh_pkg::CX_W-1:0]   x_step, y_step;
    logic signed [rpoh_pkg::CZ_W-1:0]   z_step;
    logic signed [rpoh_pkg::CX_W-1:0]   c_full, s_full;
    logic signed [rpoh_pkg::TRIG_W-1:0] c_r, s_r;

    // angle to q16 radians, rounded
    assign z_prod = 33'(req.angle[13:0]) * 33'(rpoh_pkg::Z_SCALE);
    assign z_rnd  = z_prod + 33'd32768;
    assign z_init = signed'({2'b00, z_rnd[32:16]});

    assign x_sh     = x_reg >>> iter_reg;
    assign y_sh     = y_reg >>> iter_reg;
    assign atan_ext = signed'({2'b00, rpoh_pkg::atan_q16(iter_reg)});

    always_comb
    begin
        if (!z_reg[rpoh_pkg::CZ_W-1])
        begin
            x_step = x_reg - y_sh;
            y_step = y_reg + x_sh;
            z_step = z_reg - atan_ext;
        end
        else
        begin
            x_step = x_reg + y_sh;
            y_step = y_reg - x_sh;
            z_step = z_reg + atan_ext;
        end
    end

    // round to q1.15
    assign c_full = (x_reg + 32'sd16384) >>> 15;
    assign s_full = (y_reg + 32'sd16384) >>> 15;
    assign c_r    = c_full[rpoh_pkg::TRIG_W-1:0];
    assign s_r    = s_full[rpoh_pkg::TRIG_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpoh_pkg::CS_IDLE:
            begin
                if (req.start)
                begin
                    state_next = rpoh_pkg::CS_ROT;
                end
            end
            rpoh_pkg::CS_ROT:
            begin
                if (iter_reg == rpoh_pkg::ITER_W'(rpoh_pkg::CORDIC_ITERS - 1))
                begin
                    state_next = rpoh_pkg::CS_ROUND;
                end
            end
            rpoh_pkg::CS_ROUND:
            begin
                state_next = rpoh_pkg::CS_IDLE;
            end
            default:
            begin
                state_next = rpoh_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == rpoh_pkg::CS_ROUND);
        case (quad_reg)
            2'd0:
            begin
                rsp.cos_v = c_r;
                rsp.sin_v = s_r;
            end
            2'd1:
            begin
                rsp.cos_v = -s_r;
                rsp.sin_v = c_r;
            end
            2'd2:
            begin
                rsp.cos_v = -c_r;
                rsp.sin_v = -s_r;
            end
            default:
            begin
                rsp.cos_v = s_r;
                rsp.sin_v = -c_r;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpoh_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rpoh_pkg::CS_IDLE && req.start)
        begin
            x_reg    <= rpoh_pkg::CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= z_init;
            quad_reg <= req.angle[15:14];
            iter_reg <= '0;
        end
        else if (state_reg == rpoh_pkg::CS_ROT)
        begin
            x_reg    <= x_step;
            y_reg    <= y_step;
            z_reg    <= z_step;
            iter_reg <= iter_reg + 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/regular_polygon_outline_and_hit_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// regular_polygon_outline_and_hit_test: regular k-gon outline and hit test
// vertex segments or point containment against a shrunk polygon
// ----------------------------------------------------------------------------
// A word with mode 1 yields k outline segments, vertex i-1 to vertex i, the
// last one flagged; a word with mode 0 yields one hit result with last set.
// One word is handled at a time and in_stall is high until its final result
// has been loaded into the output register. Every angle (vertex or edge
// normal) goes through an angle add, launch, 16 cordic iterations plus a
// rounding step, two passes through the one shared 18x17 multiplier and an
// evaluate step. An outline word computes k+1 vertices. A hit word stops at
// the first edge that rejects the point and, when inner_radius <= margin,
// skips the edges and always answers 0. A waiting result never blocks the
// next word from being taken.
// ----------------------------------------------------------------------------
module regular_polygon_outline_and_hit_test (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [rpoh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rpoh_pkg::CFG_DATA_W-1:0]      cfg_data,
    // request channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 mode,
    input  wire logic signed [rpoh_pkg::COORD_W-1:0]  point_x,
    input  wire logic signed [rpoh_pkg::COORD_W-1:0]  point_y,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [rpoh_pkg::COORD_W-1:0]       start_x,
    output logic signed [rpoh_pkg::COORD_W-1:0]       start_y,
    output logic signed [rpoh_pkg::COORD_W-1:0]       end_x,
    output logic signed [rpoh_pkg::COORD_W-1:0]       end_y,
    output logic                                      inside_res,
    output logic                                      last
);

    localparam int CW = rpoh_pkg::COORD_W;
    localparam int RW = rpoh_pkg::RAD_W;
    localparam int SW = rpoh_pkg::SIDE_W;
    localparam int TW = rpoh_pkg::TRIG_W;
    localparam int OW = rpoh_pkg::OPND_W;
    localparam int PW = rpoh_pkg::PROD_W;
    localparam int VW = CW + 4;   // vertex sum before saturation

    // configuration registers
    logic signed [CW-1:0]          center_x_reg, center_y_reg;
    logic [RW-1:0]                 inner_reg, outer_reg, margin_reg;
    logic [rpoh_pkg::ANG_W-1:0]    rotation_reg;
    logic [SW-1:0]                 side_count_reg;

    // sequencer
    rpoh_pkg::seq_state_t state_reg, state_next;

    // per-word working registers
    logic                          mode_reg;
    logic [SW-1:0]                 k_reg;
    logic [SW-1:0]                 edge_reg;
    logic [rpoh_pkg::ANG_W-1:0]    q_reg;
    logic [SW-1:0]                 rem_reg;
    logic [rpoh_pkg::ANG_W-1:0]    angle_reg;
    logic signed [OW-1:0]          dx_reg, dy_reg;
    logic [RW-1:0]                 diff_reg;
    logic                          inside_reg;
    logic signed [TW-1:0]          cos_reg, sin_reg;
    logic signed [PW-1:0]          prod_c_reg, prod_s_reg;
    logic signed [CW-1:0]          prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic                          seg_last_reg;

    // output register
    logic                          out_valid_reg;
    logic signed [CW-1:0]          start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic                          inside_res_reg, last_reg;

    // trig unit link
    rpoh_pkg::trig_req_t           trig_req;
    rpoh_pkg::trig_rsp_t           trig_rsp;

    // combinational helpers
    logic                          in_accept;
    logic                          emit_ok, emit_fire;
    logic [SW-1:0]                 k_clamped;
    logic                          hit_empty;
    rpoh_pkg::frac_step_t          fstep, hstep;
    logic [SW:0]                   rem_sum;
    logic                          rem_wrap;
    logic signed [OW-1:0]          opnd_c, opnd_s;
    logic signed [PW-1:0]          mul_a, mul_b, prod;
    logic signed [PW-1:0]          rnd_x, rnd_y;
    logic signed [VW-1:0]          sum_x, sum_y;
    logic signed [CW-1:0]          vx, vy;
    logic signed [PW:0]            proj, limit;
    logic                          outside;
    logic                          hit_last_edge;

    rpoh_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (trig_req),
        .rsp   (trig_rsp)
    );

    // side count clamped into the supported range
    always_comb
    begin
        if (side_count_reg < SW'(rpoh_pkg::MIN_SIDES))
        begin
            k_clamped = SW'(rpoh_pkg::MIN_SIDES);
        end
        else if (side_count_reg > SW'(rpoh_pkg::MAX_SIDES))
        begin
            k_clamped = SW'(rpoh_pkg::MAX_SIDES);
        end
        else
        begin
            k_clamped = side_count_reg;
        end
    end

    assign hit_empty = (inner_reg <= margin_reg);
    assign hstep     = rpoh_pkg::half_step(k_clamped);

    // angle advance by one turn over k, kept as quotient plus remainder
    assign fstep    = rpoh_pkg::full_step(k_reg);
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, fstep.rem};
    assign rem_wrap = (rem_sum >= {1'b0, k_reg});

    // shared multiplier: cosine pass then sine pass
    assign opnd_c = mode_reg ? signed'({2'b00, outer_reg}) : dx_reg;
    assign opnd_s = mode_reg ? signed'({2'b00, outer_reg}) : dy_reg;

    always_comb
    begin
        if (state_reg == rpoh_pkg::ST_MUL_C)
        begin
            mul_a = {{(PW-TW){cos_reg[TW-1]}}, cos_reg};
            mul_b = {{(PW-OW){opnd_c[OW-1]}}, opnd_c};
        end
        else
        begin
            mul_a = {{(PW-TW){sin_reg[TW-1]}}, sin_reg};
            mul_b = {{(PW-OW){opnd_s[OW-1]}}, opnd_s};
        end
    end

    assign prod = mul_a * mul_b;

    // vertex: center plus rounded radius term, saturated
    assign rnd_x = (prod_c_reg + PW'(16384)) >>> 15;
    assign rnd_y = (prod_s_reg + PW'(16384)) >>> 15;
    assign sum_x = {{(VW-CW){center_x_reg[CW-1]}}, center_x_reg} + rnd_x[VW-1:0];
    assign sum_y = {{(VW-CW){center_y_reg[CW-1]}}, center_y_reg} + rnd_y[VW-1:0];

    always_comb
    begin
        if (sum_x > VW'(32767))
        begin
            vx = 16'sh7fff;
        end
        else if (sum_x < -VW'(32768))
        begin
            vx = -16'sh8000;
        end
        else
        begin
            vx = sum_x[CW-1:0];
        end
        if (sum_y > VW'(32767))
        begin
            vy = 16'sh7fff;
        end
        else if (sum_y < -VW'(32768))
        begin
            vy = -16'sh8000;
        end
        else
        begin
            vy = sum_y[CW-1:0];
        end
    end

    // hit test: projection on edge normal against shrunk apothem, q.15
    assign proj  = {prod_c_reg[PW-1], prod_c_reg} + {prod_s_reg[PW-1], prod_s_reg};
    assign limit = signed'({{(PW+1-RW-15){1'b0}}, diff_reg, 15'b0});
    assign outside = (proj > limit);
    assign hit_last_edge = (edge_reg == k_reg - SW'(1));

    assign emit_ok   = !out_valid_reg || !out_stall;
    assign in_accept = in_valid && (state_reg == rpoh_pkg::ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpoh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!mode && hit_empty)
                    begin
                        state_next = rpoh_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = rpoh_pkg::ST_ANGLE;
                    end
                end
            end
            rpoh_pkg::ST_ANGLE:
            begin
                state_next = rpoh_pkg::ST_LAUNCH;
            end
            rpoh_pkg::ST_LAUNCH:
            begin
                state_next = rpoh_pkg::ST_TRIG;
            end
            rpoh_pkg::ST_TRIG:
            begin
                if (trig_rsp.done)
                begin
                    state_next = rpoh_pkg::ST_MUL_C;
                end
            end
            rpoh_pkg::ST_MUL_C:
            begin
                state_next = rpoh_pkg::ST_MUL_S;
            end
            rpoh_pkg::ST_MUL_S:
            begin
                state_next = rpoh_pkg::ST_EVAL;
            end
            rpoh_pkg::ST_EVAL:
            begin
                if (mode_reg)
                begin
                    // vertex 0 only opens the first segment
                    if (edge_reg == '0)
                    begin
                        state_next = rpoh_pkg::ST_ANGLE;
                    end
                    else
                    begin
                        state_next = rpoh_pkg::ST_EMIT;
                    end
                end
                else if (outside || hit_last_edge)
                begin
                    state_next = rpoh_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = rpoh_pkg::ST_ANGLE;
                end
            end
            rpoh_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    if (mode_reg && !seg_last_reg)
                    begin
                        state_next = rpoh_pkg::ST_ANGLE;
                    end
                    else
                    begin
                        state_next = rpoh_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rpoh_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall       = (state_reg != rpoh_pkg::ST_IDLE);
        trig_req.start = (state_reg == rpoh_pkg::ST_LAUNCH);
        trig_req.angle = angle_reg;
        emit_fire      = (state_reg == rpoh_pkg::ST_EMIT) && emit_ok;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpoh_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            inner_reg      <= '0;
            outer_reg      <= '0;
            margin_reg     <= RW'(24);
            rotation_reg   <= '0;
            side_count_reg <= SW'(rpoh_pkg::MIN_SIDES);
        end
        else if (cfg_we)
        begin
            case (rpoh_pkg::cfg_index_t'(cfg_index))
                rpoh_pkg::CFG_CENTER_X: center_x_reg   <= signed'(cfg_data);
                rpoh_pkg::CFG_CENTER_Y: center_y_reg   <= signed'(cfg_data);
                rpoh_pkg::CFG_INNER:    inner_reg      <= cfg_data[RW-1:0];
                rpoh_pkg::CFG_OUTER:    outer_reg      <= cfg_data[RW-1:0];
                rpoh_pkg::CFG_MARGIN:   margin_reg     <= cfg_data[RW-1:0];
                rpoh_pkg::CFG_ROTATION: rotation_reg   <= cfg_data;
                rpoh_pkg::CFG_SIDES:    side_count_reg <= cfg_data[SW-1:0];
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg   <= mode;
            k_reg      <= k_clamped;
            edge_reg   <= '0;
            dx_reg     <= {point_x[CW-1], point_x} - {center_x_reg[CW-1], center_x_reg};
            dy_reg     <= {point_y[CW-1], point_y} - {center_y_reg[CW-1], center_y_reg};
            diff_reg   <= inner_reg - margin_reg;
            inside_reg <= !hit_empty;
            if (mode)
            begin
                q_reg   <= '0;
                rem_reg <= '0;
            end
            else
            begin
                // edge normals sit half a step past the vertices
                q_reg   <= hstep.quo;
                rem_reg <= hstep.rem;
            end
        end

        if (state_reg == rpoh_pkg::ST_ANGLE)
        begin
            angle_reg <= rotation_reg + q_reg;
        end

        if (state_reg == rpoh_pkg::ST_TRIG && trig_rsp.done)
        begin
            cos_reg <= trig_rsp.cos_v;
            sin_reg <= trig_rsp.sin_v;
        end

        if (state_reg == rpoh_pkg::ST_MUL_C)
        begin
            prod_c_reg <= prod;
        end

        if (state_reg == rpoh_pkg::ST_MUL_S)
        begin
            prod_s_reg <= prod;
        end

        if (state_reg == rpoh_pkg::ST_EVAL)
        begin
            edge_reg <= edge_reg + SW'(1);
            if (rem_wrap)
            begin
                rem_reg <= SW'(rem_sum - {1'b0, k_reg});
                q_reg   <= q_reg + fstep.quo + 16'd1;
            end
            else
            begin
                rem_reg <= rem_sum[SW-1:0];
                q_reg   <= q_reg + fstep.quo;
            end
            if (mode_reg)
            begin
                if (edge_reg == '0)
                begin
                    prev_x_reg <= vx;
                    prev_y_reg <= vy;
                end
                else
                begin
                    cur_x_reg <= vx;
                    cur_y_reg <= vy;
                end
                seg_last_reg <= (edge_reg == k_reg);
            end
            else if (outside)
            begin
                inside_reg <= 1'b0;
            end
        end

        if (emit_fire && mode_reg)
        begin
            // end vertex opens the next segment
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            if (mode_reg)
            begin
                start_x_reg    <= prev_x_reg;
                start_y_reg    <= prev_y_reg;
                end_x_reg      <= cur_x_reg;
                end_y_reg      <= cur_y_reg;
                inside_res_reg <= 1'b0;
                last_reg       <= seg_last_reg;
            end
            else
            begin
                start_x_reg    <= '0;
                start_y_reg    <= '0;
                end_x_reg      <= '0;
                end_y_reg      <= '0;
                inside_res_reg <= inside_reg;
                last_reg       <= 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign start_x    = start_x_reg;
    assign start_y    = start_y_reg;
    assign end_x      = end_x_reg;
    assign end_y      = end_y_reg;
    assign inside_res = inside_res_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire
